[rtl/scpc_pkg.sv]
// Shared codes, widths, reset values and the percentage scale table of the position controller.
`default_nettype none

package scpc_pkg;

   // field widths fixed by the interface
   localparam int FUNC_W     = 2;
   localparam int CMD_W      = 2;
   localparam int MODE_W     = 3;
   localparam int DIR_W      = 2;
   localparam int THRESH_W   = 12;
   localparam int PCT_W      = 7;
   localparam int END_W      = 15;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 15;

   // bits of a response other than the position and the current
   localparam int RSP_FIXED_W = MODE_W + DIR_W + 1 + 2 * END_W;

   // event kinds carried in tuser
   localparam logic [FUNC_W-1:0] FUNC_COMMAND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_PULSE   = 2'd3;

   localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ON_POS    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OFF_POS   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_HALT      = 2'd3;

   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TO_UPPER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WAIT_LOW = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TO_LOWER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MOVING   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READY    = 3'd5;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_STALL_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GET_ON_PERCENT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GET_OFF_PERCENT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_POSITION  = 2'd3;

   localparam logic [THRESH_W-1:0] STALL_THRESHOLD_RST = 12'd2800;
   localparam logic [PCT_W-1:0]    GET_ON_PERCENT_RST  = 7'd50;
   localparam logic [PCT_W-1:0]    GET_OFF_PERCENT_RST = 7'd10;
   localparam logic [END_W-1:0]    START_POSITION_RST  = 15'd1000;

   localparam logic [END_W-1:0] END_MAX = 15'h7FFF;

   // upper * pct / 100 is done as upper * ceil(pct * 2^22 / 100) >> 22;
   // 2^22 > 100 * 2^15 keeps the floor exact for every 15-bit stroke
   localparam int PCT_FULL    = 100;
   localparam int SCALE_SHIFT = 22;
   localparam int SCALE_W     = SCALE_SHIFT + 1;

   typedef logic [SCALE_W-1:0] scale_type;

   // constant table over all 7-bit percentages, clamped at full stroke
   function automatic scale_type pct_scale(input logic [PCT_W-1:0] pct);
      scale_type r;
      r = '0;
      for (int i = 0; i < (1 << PCT_W); i++) begin
         if (pct == PCT_W'(i)) begin
            if (i >= PCT_FULL) begin
               r = SCALE_W'(1 << SCALE_SHIFT);
            end else begin
               r = SCALE_W'((i * (1 << SCALE_SHIFT) + PCT_FULL - 1) / PCT_FULL);
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/stall_calibrated_position_controller_top.sv]
// Top level of the stall-calibrated position controller: event decode, state and response register.
//
//  Channel   Direction  Handshake                  Content
//  req_      in         req_tvalid / req_tready    tuser: func; tdata: command, current_sample
//  rsp_      out        rsp_tvalid / rsp_tready    tdata: state after each request
//  csr_      in         csr_we                     csr_addr selects one of four registers
//
//  One request per cycle while req_tready is high: the state is updated at the edge that takes the
//  request and the response register is loaded in the same edge, so the response is valid in the next cycle.
//  The longest path is the stroke times percentage-scale multiply and the position compare.
//  req_tready is low only while a response waits and rsp_tready is low.
//  reset is synchronous: mode idle, motor stopped, position at the reset start position,
//  registers at their defaults, no response pending.
`default_nettype none

module stall_calibrated_position_controller_top #(
   parameter int POSITION_WIDTH = 16,
   parameter int SAMPLE_WIDTH   = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // from bit 0: command, current_sample, zero fill
   input  wire logic [((scpc_pkg::CMD_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // func
   input  wire logic [scpc_pkg::FUNC_W-1:0]             req_tuser,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // from bit 0: mode, direction, calibrated, position, upper_end, target,
   // latched_current, zero fill
   output logic [((scpc_pkg::RSP_FIXED_W + POSITION_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]
                                                        rsp_tdata,
   input  wire logic                                    csr_we,
   input  wire logic [scpc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [scpc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int P       = POSITION_WIDTH;
   localparam int S       = SAMPLE_WIDTH;
   localparam int RSP_W   = ((scpc_pkg::RSP_FIXED_W + P + S + 7) / 8) * 8;
   localparam int CMP_W   = ((P > scpc_pkg::END_W) ? P : scpc_pkg::END_W) + 1;
   localparam int CUR_W   = (S > scpc_pkg::THRESH_W) ? S : scpc_pkg::THRESH_W;
   localparam int PROD_W  = scpc_pkg::END_W + scpc_pkg::SCALE_W;
   localparam logic [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
   localparam logic [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

   // start position limited to the positive range of the position counter
   function automatic logic [P-1:0] clamp_start(input logic [scpc_pkg::END_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext > CMP_W'(POS_MAX)) begin
         return POS_MAX;
      end
      return P'(ext);
   endfunction

   // configuration
   logic [scpc_pkg::THRESH_W-1:0] thresh_ff,  thresh_in;
   logic [scpc_pkg::PCT_W-1:0]    on_pct_ff,  on_pct_in;
   logic [scpc_pkg::PCT_W-1:0]    off_pct_ff, off_pct_in;
   logic [scpc_pkg::END_W-1:0]    start_ff,   start_in;

   // controller state
   logic [scpc_pkg::MODE_W-1:0]   mode_ff,   mode_in;
   logic [scpc_pkg::DIR_W-1:0]    dir_ff,    dir_in;
   logic [S-1:0]                  cur_ff,    cur_in;
   logic                          cal_ff,    cal_in;
   logic [P-1:0]                  pos_ff,    pos_in;
   logic [scpc_pkg::END_W-1:0]    upper_ff,  upper_in;
   logic [scpc_pkg::END_W-1:0]    target_ff, target_in;
   logic [scpc_pkg::END_W-1:0]    stroke_ff, stroke_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff,  rsp_data_in;

   logic                          accept;
   logic [scpc_pkg::CMD_W-1:0]    cmd;
   logic [S-1:0]                  sample;
   logic                          stalled;
   logic [scpc_pkg::PCT_W-1:0]    move_pct;
   logic [PROD_W-1:0]             product;
   logic [scpc_pkg::END_W-1:0]    goal;
   logic signed [CMP_W-1:0]       pos_ext;
   logic signed [CMP_W-1:0]       goal_ext;
   logic signed [CMP_W-1:0]       step_ext;
   logic signed [CMP_W-1:0]       target_ext;
   logic                          cw;
   logic [P-1:0]                  pos_step;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign cmd        = req_tdata[scpc_pkg::CMD_W-1:0];
   assign sample     = req_tdata[scpc_pkg::CMD_W +: S];

   assign stalled = CUR_W'(cur_ff) >= CUR_W'(thresh_ff);

   // move target from the stroke
   assign move_pct = (cmd == scpc_pkg::CMD_ON_POS) ? on_pct_ff : off_pct_ff;
   assign product  = PROD_W'(upper_ff) * PROD_W'(scpc_pkg::pct_scale(move_pct));
   assign goal     = product[scpc_pkg::SCALE_SHIFT +: scpc_pkg::END_W];

   assign pos_ext  = signed'({{(CMP_W-P){pos_ff[P-1]}}, pos_ff});
   assign goal_ext = signed'(CMP_W'(goal));

   // saturating encoder step
   assign cw = (dir_ff == scpc_pkg::DIR_CW);
   always_comb begin
      if (cw) begin
         pos_step = (pos_ff == POS_MAX) ? pos_ff : pos_ff + P'(1);
      end else begin
         pos_step = (pos_ff == POS_MIN) ? pos_ff : pos_ff - P'(1);
      end
   end
   assign step_ext   = signed'({{(CMP_W-P){pos_step[P-1]}}, pos_step});
   assign target_ext = signed'(CMP_W'(target_ff));

   always_comb begin
      thresh_in  = thresh_ff;
      on_pct_in  = on_pct_ff;
      off_pct_in = off_pct_ff;
      start_in   = start_ff;
      if (csr_we) begin
         unique case (csr_addr)
            scpc_pkg::CSR_STALL_THRESHOLD: thresh_in  = csr_wdata[scpc_pkg::THRESH_W-1:0];
            scpc_pkg::CSR_GET_ON_PERCENT:  on_pct_in  = csr_wdata[scpc_pkg::PCT_W-1:0];
            scpc_pkg::CSR_GET_OFF_PERCENT: off_pct_in = csr_wdata[scpc_pkg::PCT_W-1:0];
            scpc_pkg::CSR_START_POSITION:  start_in   = csr_wdata[scpc_pkg::END_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      dir_in    = dir_ff;
      cur_in    = cur_ff;
      cal_in    = cal_ff;
      pos_in    = pos_ff;
      upper_in  = upper_ff;
      target_in = target_ff;
      stroke_in = stroke_ff;
      if (accept) begin
         unique case (req_tuser)
            scpc_pkg::FUNC_COMMAND: begin
               unique case (cmd) inside
                  scpc_pkg::CMD_CALIBRATE: begin
                     cal_in    = 1'b0;
                     pos_in    = clamp_start(start_ff);
                     upper_in  = '0;
                     stroke_in = '0;
                     mode_in   = scpc_pkg::MODE_TO_UPPER;
                     dir_in    = scpc_pkg::DIR_CW;
                  end
                  scpc_pkg::CMD_ON_POS, scpc_pkg::CMD_OFF_POS: begin
                     if (cal_ff) begin
                        target_in = goal;
                        mode_in   = scpc_pkg::MODE_MOVING;
                        if (pos_ext < goal_ext) begin
                           dir_in = scpc_pkg::DIR_CW;
                        end else if (pos_ext > goal_ext) begin
                           dir_in = scpc_pkg::DIR_CCW;
                        end else begin
                           dir_in  = scpc_pkg::DIR_STOP;
                           mode_in = scpc_pkg::MODE_READY;
                        end
                     end
                  end
                  scpc_pkg::CMD_HALT: begin
                     dir_in  = scpc_pkg::DIR_STOP;
                     mode_in = scpc_pkg::MODE_IDLE;
                  end
                  default: ;
               endcase
            end
            scpc_pkg::FUNC_SAMPLE: begin
               cur_in = sample;
            end
            scpc_pkg::FUNC_TICK: begin
               if (mode_ff == scpc_pkg::MODE_TO_UPPER && stalled) begin
                  dir_in  = scpc_pkg::DIR_STOP;
                  mode_in = scpc_pkg::MODE_WAIT_LOW;
               end else if (mode_ff == scpc_pkg::MODE_WAIT_LOW && !stalled) begin
                  stroke_in = '0;
                  mode_in   = scpc_pkg::MODE_TO_LOWER;
                  dir_in    = scpc_pkg::DIR_CCW;
               end else if (mode_ff == scpc_pkg::MODE_TO_LOWER && stalled) begin
                  upper_in = stroke_ff;
                  pos_in   = '0;
                  cal_in   = 1'b1;
                  dir_in   = scpc_pkg::DIR_STOP;
                  mode_in  = scpc_pkg::MODE_READY;
               end
            end
            scpc_pkg::FUNC_PULSE: begin
               if (mode_ff == scpc_pkg::MODE_TO_LOWER) begin
                  if (stroke_ff != scpc_pkg::END_MAX) begin
                     stroke_in = stroke_ff + scpc_pkg::END_W'(1);
                  end
               end else if (mode_ff == scpc_pkg::MODE_MOVING) begin
                  pos_in = pos_step;
                  // stop once the target is reached or overshot
                  if ((cw && step_ext >= target_ext) ||
                      (dir_ff == scpc_pkg::DIR_CCW && step_ext <= target_ext)) begin
                     dir_in  = scpc_pkg::DIR_STOP;
                     mode_in = scpc_pkg::MODE_READY;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data_in  = RSP_W'({cur_in, target_in, upper_in, pos_in, cal_in, dir_in, mode_in});
      rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= scpc_pkg::STALL_THRESHOLD_RST;
         on_pct_ff    <= scpc_pkg::GET_ON_PERCENT_RST;
         off_pct_ff   <= scpc_pkg::GET_OFF_PERCENT_RST;
         start_ff     <= scpc_pkg::START_POSITION_RST;
         mode_ff      <= scpc_pkg::MODE_IDLE;
         dir_ff       <= scpc_pkg::DIR_STOP;
         cur_ff       <= '0;
         cal_ff       <= 1'b0;
         pos_ff       <= clamp_start(scpc_pkg::START_POSITION_RST);
         upper_ff     <= '0;
         target_ff    <= '0;
         stroke_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         on_pct_ff    <= on_pct_in;
         off_pct_ff   <= off_pct_in;
         start_ff     <= start_in;
         mode_ff      <= mode_in;
         dir_ff       <= dir_in;
         cur_ff       <= cur_in;
         cal_ff       <= cal_in;
         pos_ff       <= pos_in;
         upper_ff     <= upper_in;
         target_ff    <= target_in;
         stroke_ff    <= stroke_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/scpc_checker.sv]
// Port-level checks on the position controller's responses, bound to the top level.
`default_nettype none

module scpc_checker #(
   parameter int POSITION_WIDTH = 16,
   parameter int SAMPLE_WIDTH   = 12
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((scpc_pkg::RSP_FIXED_W + POSITION_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]
                    rsp_tdata
);

   logic [scpc_pkg::MODE_W-1:0] mode;
   logic [scpc_pkg::DIR_W-1:0]  dir;
   logic                        cal;

   assign mode = rsp_tdata[scpc_pkg::MODE_W-1:0];
   assign dir  = rsp_tdata[scpc_pkg::MODE_W +: scpc_pkg::DIR_W];
   assign cal  = rsp_tdata[scpc_pkg::MODE_W + scpc_pkg::DIR_W];

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // motor is off in the resting modes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode == scpc_pkg::MODE_IDLE || mode == scpc_pkg::MODE_WAIT_LOW ||
                     mode == scpc_pkg::MODE_READY) |-> dir == scpc_pkg::DIR_STOP)
      else $error("motor driven in a resting mode");

   // calibration runs drive towards the stop being sought
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode == scpc_pkg::MODE_TO_UPPER || mode == scpc_pkg::MODE_TO_LOWER) |->
      ((mode == scpc_pkg::MODE_TO_UPPER && dir == scpc_pkg::DIR_CW) ||
       (mode == scpc_pkg::MODE_TO_LOWER && dir == scpc_pkg::DIR_CCW)))
      else $error("wrong drive direction during calibration");

   // moves and the ready state only exist after a finished calibration
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode == scpc_pkg::MODE_MOVING || mode == scpc_pkg::MODE_READY) |-> cal)
      else $error("move or ready without calibration");

endmodule

bind stall_calibrated_position_controller_top scpc_checker #(
   .POSITION_WIDTH (POSITION_WIDTH),
   .SAMPLE_WIDTH   (SAMPLE_WIDTH)
) u_scpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
